>>> design/max_m_subsegment_sum_defines.svh
// ----------------------------------------------------------------------------
// max_m_subsegment_sum_defines.svh
// Assertion macros shared by the m-subsegment sum modules. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MAX_M_SUBSEGMENT_SUM_DEFINES_SVH
`define MAX_M_SUBSEGMENT_SUM_DEFINES_SVH

// same-cycle implication
`define MMSS_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmss assertion failed");

// next-cycle implication
`define MMSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmss assertion failed");

`endif

>>> design/mmss_pkg.sv
// ----------------------------------------------------------------------------
// mmss_pkg
// Sizes, constants and shared types of the m-subsegment sum block.
// ----------------------------------------------------------------------------
package mmss_pkg;

    localparam int MAX_LEN      = 1024;
    localparam int MAX_SEGMENTS = 64;

    localparam int SAMPLE_W = 16;
    localparam int SEG_W    = 7;
    localparam int TOTAL_W  = 25;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SUM_W    = $clog2(MAX_LEN) + SAMPLE_W;

    localparam int SEG_CAP = (MAX_SEGMENTS > 127) ? 127 : MAX_SEGMENTS;
    localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'(SEG_CAP);

    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SEG_W-1:0] segs;
    } job_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } sample_wr_t;

endpackage

>>> design/mmss_front.sv
// ----------------------------------------------------------------------------
// mmss_front
// Accepts sample words, forwards them to the sample store, counts the
// sequence, holds segment_count and issues one job per sequence.
// ----------------------------------------------------------------------------
module mmss_front
    import mmss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       is_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [SEG_W-1:0]           cfg_data,
    input  logic                       unlock,
    output logic                       job_push,
    output job_t                       job,
    output sample_wr_t                 sample_wr
);

    logic [LEN_W-1:0] count_reg;
    logic             locked_reg;
    logic [SEG_W-1:0] seg_count_reg;

    logic             accept;
    logic             room;
    logic [LEN_W-1:0] len_now;

    assign accept    = in_valid && !locked_reg;
    assign room      = count_reg < LEN_W'(MAX_LEN);
    assign len_now   = room ? (count_reg + LEN_W'(1)) : count_reg;
    assign in_stall  = locked_reg;
    assign cfg_ready = 1'b1;

    assign sample_wr.en   = accept && room;
    assign sample_wr.addr = count_reg[ADDR_W-1:0];
    assign sample_wr.data = sample_value;

    assign job_push = accept && is_last;
    assign job.len  = len_now;
    assign job.segs = (seg_count_reg > SEG_LIMIT) ? SEG_LIMIT : seg_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            locked_reg    <= 1'b0;
            seg_count_reg <= SEG_W'(1);
        end
        else
        begin
            if (cfg_valid)
            begin
                seg_count_reg <= cfg_data;
            end
            if (unlock)
            begin
                locked_reg <= 1'b0;
            end
            if (accept)
            begin
                if (is_last)
                begin
                    count_reg  <= '0;
                    locked_reg <= 1'b1;
                end
                else if (room)
                begin
                    count_reg <= count_reg + LEN_W'(1);
                end
            end
        end
    end

endmodule

>>> design/mmss_job_queue.sv
// ----------------------------------------------------------------------------
// mmss_job_queue
// Short job queue between the loading front and the compute back.
// ----------------------------------------------------------------------------
module mmss_job_queue
    import mmss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t               entry_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] wr_ptr_reg;
    logic [JOBQ_AW-1:0] rd_ptr_reg;
    logic [JOBQ_CW-1:0] fill_reg;

    logic               full;
    logic               do_push;
    logic               do_pop;
    logic [JOBQ_AW-1:0] wr_ptr_next;
    logic [JOBQ_AW-1:0] rd_ptr_next;

    assign full       = fill_reg == JOBQ_CW'(JOBQ_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + JOBQ_AW'(1);
    assign rd_ptr_next = (rd_ptr_reg == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + JOBQ_AW'(1);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + JOBQ_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - JOBQ_CW'(1);
            end
        end
    end

endmodule

>>> design/mmss_back.sv
// ----------------------------------------------------------------------------
// mmss_back
// Row-by-row engine of the two-row programme: holds the sample store and the
// prior-best row, runs one position per cycle and registers the result word.
// ----------------------------------------------------------------------------
`include "max_m_subsegment_sum_defines.svh"

module mmss_back
    import mmss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sample_wr_t         sample_wr,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    output logic               unlock,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TOTAL_W-1:0] best_total
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HEAD,
        S_STEP,
        S_ROW_END,
        S_DONE
    } state_t;

    logic signed [SAMPLE_W-1:0] sample_mem [MAX_LEN];
    logic signed [SUM_W-1:0]    prior_mem  [MAX_LEN + 1];
    logic signed [SAMPLE_W-1:0] s_rd;
    logic signed [SUM_W-1:0]    p_rd;

    state_t                  state_reg,      state_next;
    logic [SEG_W-1:0]        i_reg,          i_next;
    logic [SEG_W-1:0]        m_reg,          m_next;
    logic [LEN_W-1:0]        n_reg,          n_next;
    logic [LEN_W-1:0]        span_reg,       span_next;
    logic [LEN_W-1:0]        k_reg,          k_next;
    logic [LEN_W-1:0]        cnt_reg,        cnt_next;
    logic signed [SUM_W-1:0] efirst_reg,     efirst_next;
    logic signed [SUM_W-1:0] eprev_reg,      eprev_next;
    logic signed [SUM_W-1:0] rmax_reg,       rmax_next;
    logic                    out_valid_reg,  out_valid_next;
    logic [TOTAL_W-1:0]      best_total_reg, best_total_next;

    logic [LEN_W-1:0]        rd_addr;
    logic                    p_we;
    logic [LEN_W-1:0]        p_waddr;
    logic signed [SUM_W-1:0] p_wdata;

    logic                    trivial;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] fresh;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] step_sum;
    logic signed [SUM_W-1:0] head_sum;
    logic [LEN_W-1:0]        end_addr;
    logic                    out_free;

    assign out_valid  = out_valid_reg;
    assign best_total = best_total_reg;

    assign trivial    = (job.segs == '0) || (job.len < LEN_W'(job.segs));
    assign sample_ext = SUM_W'(s_rd);
    assign end_addr   = LEN_W'(i_reg) + span_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign step_sum   = base + sample_ext;
    assign head_sum   = efirst_reg + sample_ext;

    always_comb
    begin
        if (i_reg == SEG_W'(1))
        begin
            fresh = '0;
        end
        else
        begin
            fresh = p_rd;
        end
        if (eprev_reg > fresh)
        begin
            base = eprev_reg;
        end
        else
        begin
            base = fresh;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        m_next          = m_reg;
        n_next          = n_reg;
        span_next       = span_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        efirst_next     = efirst_reg;
        eprev_next      = eprev_reg;
        rmax_next       = rmax_reg;
        out_valid_next  = out_valid_reg && out_stall;
        best_total_next = best_total_reg;
        job_pop         = 1'b0;
        unlock          = 1'b0;
        rd_addr         = k_reg;
        p_we            = 1'b0;
        p_waddr         = k_reg;
        p_wdata         = rmax_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    n_next      = job.len;
                    m_next      = job.segs;
                    span_next   = job.len - LEN_W'(job.segs);
                    i_next      = SEG_W'(1);
                    efirst_next = '0;
                    rmax_next   = '0;
                    if (trivial)
                    begin
                        unlock     = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                rd_addr    = '0;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                efirst_next = head_sum;
                eprev_next  = head_sum;
                rmax_next   = head_sum;
                if (span_reg == '0)
                begin
                    state_next = S_ROW_END;
                end
                else
                begin
                    rd_addr    = LEN_W'(i_reg);
                    k_next     = LEN_W'(i_reg);
                    cnt_next   = span_reg;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                p_we       = 1'b1;
                p_waddr    = k_reg;
                p_wdata    = rmax_reg;
                eprev_next = step_sum;
                if (rmax_reg < step_sum)
                begin
                    rmax_next = step_sum;
                end
                if (cnt_reg == LEN_W'(1))
                begin
                    state_next = S_ROW_END;
                end
                else
                begin
                    k_next     = k_reg + LEN_W'(1);
                    rd_addr    = k_reg + LEN_W'(1);
                    cnt_next   = cnt_reg - LEN_W'(1);
                end
            end
            S_ROW_END:
            begin
                p_we    = 1'b1;
                p_waddr = end_addr;
                p_wdata = rmax_reg;
                if (i_reg == m_reg)
                begin
                    unlock     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = LEN_W'(i_reg);
                    i_next     = i_reg + SEG_W'(1);
                    state_next = S_HEAD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!rmax_reg[SUM_W-1] && (rmax_reg != '0))
                    begin
                        best_total_next = TOTAL_W'(unsigned'(rmax_reg));
                    end
                    else
                    begin
                        best_total_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sample_wr.en)
        begin
            sample_mem[sample_wr.addr] <= sample_wr.data;
        end
        s_rd <= sample_mem[rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prior_mem[p_waddr] <= p_wdata;
        end
        p_rd <= prior_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            m_reg          <= '0;
            n_reg          <= '0;
            span_reg       <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            efirst_reg     <= '0;
            eprev_reg      <= '0;
            rmax_reg       <= '0;
            out_valid_reg  <= 1'b0;
            best_total_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            m_reg          <= m_next;
            n_reg          <= n_next;
            span_reg       <= span_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            efirst_reg     <= efirst_next;
            eprev_reg      <= eprev_next;
            rmax_reg       <= rmax_next;
            out_valid_reg  <= out_valid_next;
            best_total_reg <= best_total_next;
        end
    end

    `MMSS_ASSERT_HOLDS(a_step_count_live, state_reg == S_STEP, cnt_reg != '0)
    `MMSS_ASSERT_HOLDS(a_row_end_in_range, state_reg == S_ROW_END, end_addr <= n_reg)
    `MMSS_ASSERT_NEXT(a_pop_leaves_idle, job_pop, state_reg != S_IDLE)
    `MMSS_ASSERT_NEXT(a_unlock_then_done, unlock, state_reg == S_DONE)

endmodule

>>> design/max_m_subsegment_sum.sv
// Loading: one sample word per cycle; samples beyond MAX_LEN are dropped.
// Compute: after the last word, one DP position per cycle through the
// prior-best row memory; n = stored samples, m = segments.
// Input stalls from the last word until the final row ends; a result may wait.
// Reset: asynchronous, active low; segment_count returns to 1, stores uncleared.
// ----------------------------------------------------------------------------
// max_m_subsegment_sum
// Greatest total of m disjoint contiguous subsegments of a loaded sequence.
// ----------------------------------------------------------------------------
module max_m_subsegment_sum
    import mmss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       is_last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [TOTAL_W-1:0]         best_total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [SEG_W-1:0]           cfg_data
);

    logic       unlock;
    logic       job_push;
    job_t       push_job;
    logic       job_valid;
    job_t       head_job;
    logic       job_pop;
    sample_wr_t sample_wr;

    mmss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .unlock       (unlock),
        .job_push     (job_push),
        .job          (push_job),
        .sample_wr    (sample_wr)
    );

    mmss_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_job   (head_job)
    );

    mmss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_wr  (sample_wr),
        .job_valid  (job_valid),
        .job        (head_job),
        .job_pop    (job_pop),
        .unlock     (unlock),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_total (best_total)
    );

endmodule

>>> tb/max_m_subsegment_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_m_subsegment_sum_tb
// Self-checking bench for the m-subsegment sum block. Sequences of signed
// samples are streamed in and the totals are predicted with a two-row DP
// kept in the bench. Directed cases cover the corners, then random
// sequences run under several segment counts and idling mixes.
// ----------------------------------------------------------------------------
module max_m_subsegment_sum_tb;
    import mmss_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 40;
    localparam int SETTLE_WAIT  = 8;
    localparam int END_WAIT     = 64;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                       is_last      = 1'b0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic [TOTAL_W-1:0]         best_total;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [SEG_W-1:0]           cfg_data     = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] loaded_samples [MAX_LEN];
    int unsigned                loaded_len  = 0;
    logic [SEG_W-1:0]           seg_setting = SEG_W'(1);
    longint                     ending_sum [0:MAX_LEN];
    longint                     prior_max  [0:MAX_LEN];

    logic [TOTAL_W-1:0] expected_totals [$];
    logic [TOTAL_W-1:0] oldest_total;
    int                 error_count   = 0;
    int                 cycle_count   = 0;
    int                 send_idle_pct = 15;
    int                 recv_idle_pct = 52;
    int                 hold_requests = 0;
    int                 holds_served  = 0;
    int                 hold_left     = 0;

    max_m_subsegment_sum dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .best_total   (best_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("best_total word with no expectation: actual %0d", best_total);
                error_count++;
            end
            else
            begin
                oldest_total = expected_totals.pop_front();
                if (best_total !== oldest_total)
                begin
                    $error("best_total mismatch: expected %0d, actual %0d",
                           oldest_total, best_total);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [TOTAL_W-1:0] predict_total(input int n,
                                                          input logic [SEG_W-1:0] segs);
        int     m;
        longint run_max;
        longint base;
        longint total;
        m = int'(segs);
        if (m > MAX_SEGMENTS)
            m = MAX_SEGMENTS;
        if (m == 0 || n < m)
            return '0;
        for (int k = 0; k <= n; k++)
        begin
            ending_sum[k] = 0;
            prior_max[k]  = 0;
        end
        for (int i = 1; i <= m; i++)
        begin
            ending_sum[i] = ending_sum[i-1] + longint'(loaded_samples[i-1]);
            run_max = ending_sum[i];
            for (int j = i + 1; j <= i + n - m; j++)
            begin
                base = (ending_sum[j-1] > prior_max[j-1]) ? ending_sum[j-1] : prior_max[j-1];
                ending_sum[j]  = base + longint'(loaded_samples[j-1]);
                prior_max[j-1] = run_max;
                if (run_max < ending_sum[j])
                    run_max = ending_sum[j];
            end
            prior_max[i+n-m] = run_max;
        end
        total = 0;
        for (int j = m; j <= n; j++)
            if (total < ending_sum[j])
                total = ending_sum[j];
        return total[TOTAL_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return SAMPLE_W'($urandom_range(0, 65535));
            default: return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    // offer one word; valid stays high after acceptance until the next call
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        is_last      <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (loaded_len < MAX_LEN)
        begin
            loaded_samples[loaded_len] = value;
            loaded_len++;
        end
        if (last)
        begin
            expected_totals.push_back(predict_total(loaded_len, seg_setting));
            loaded_len = 0;
        end
    endtask

    task automatic send_sequence(input int len);
        for (int k = 0; k < len; k++)
            send_sample(random_sample(), k == len - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_segment_count(input logic [SEG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        seg_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset value of one segment
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd3, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        // zero segments
        write_segment_count(SEG_W'(0));
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd200, 1'b1);
        // too short, then just long enough
        write_segment_count(SEG_W'(3));
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd20, 1'b1);
        send_sample(16'sd10, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd20, 1'b1);
        // sample extremes
        write_segment_count(SEG_W'(2));
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(-16'sd9, 1'b1);
    endtask

    task automatic test_segment_cap();
        write_segment_count(SEG_W'(127));
        for (int k = 0; k < MAX_SEGMENTS + 2; k++)
            send_sample(16'sd1, k == MAX_SEGMENTS + 1);
        write_segment_count(SEG_W'(MAX_SEGMENTS + 1));
        send_sequence(MAX_SEGMENTS + 5);
    endtask

    // fill the store with the largest sample, then offer words to drop
    task automatic test_full_length();
        write_segment_count(SEG_W'(MAX_SEGMENTS));
        for (int k = 0; k < MAX_LEN + 6; k++)
            send_sample((k < MAX_LEN) ? 16'sh7FFF : 16'sh8000, k == MAX_LEN + 5);
    endtask

    task automatic test_backpressure();
        write_segment_count(SEG_W'(2));
        hold_requests++;
        for (int s = 0; s < 12; s++)
            send_sequence($urandom_range(3, 6));
        wait_drained();
        for (int s = 0; s < 6; s++)
            send_sequence($urandom_range(2, 8));
    endtask

    task automatic test_random();
        int phase_segs [6];
        int sent;
        int eff;
        int len;
        phase_segs = '{1, 2, 3, 0, 127, 4};
        phase_segs[2] = $urandom_range(3, 12);
        phase_segs[5] = $urandom_range(4, 20);
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 52;
            end
            else if (p < 4)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_segment_count(SEG_W'(phase_segs[p]));
            eff  = (phase_segs[p] > MAX_SEGMENTS) ? MAX_SEGMENTS : phase_segs[p];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (eff == 0)
                    len = $urandom_range(1, 20);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, eff);
                else
                    len = eff + $urandom_range(0, 20);
                send_sequence(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_segment_cap();
        test_full_length();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
